[design/pdu_pkg.sv]
`default_nettype none
package pdu_pkg;

    localparam int FRAC = 28;
    localparam int DIV_STEPS = 32;
    // pre stage + one stage per quotient bit + sign/saturate stage
    localparam int DIV_LAT = DIV_STEPS + 2;
    localparam int CELL_LAT = 6 + DIV_LAT;
    localparam int K1_LAT = 6 + 2 * DIV_LAT;

    localparam logic signed [31:0] ONE_Q = 32'sh1000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = $signed(32'h8000_0000);
    localparam logic signed [71:0] SAT_HI = 72'sh7fff_ffff;
    localparam logic signed [71:0] SAT_LO = $signed({{40{1'b1}}, 32'h8000_0000});
    localparam logic signed [71:0] HALF_Q = 72'sd134217728;

    localparam logic [2:0] REG_INV_FX = 3'd0;
    localparam logic [2:0] REG_INV_FY = 3'd1;
    localparam logic [2:0] REG_PP     = 3'd2;
    localparam logic [2:0] REG_K1     = 3'd3;
    localparam logic [2:0] REG_K2     = 3'd4;
    localparam logic [2:0] REG_K3     = 3'd5;
    localparam logic [2:0] REG_P1     = 3'd6;
    localparam logic [2:0] REG_P2     = 3'd7;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } coef_t;

    typedef struct packed {
        logic [31:0]        depth;
        logic signed [31:0] yd;
        logic signed [31:0] xd;
    } item_t;

    typedef struct packed {
        logic neg;
        logic apos;
        logic aneg;
        logic ovf;
    } dflag_t;

    function automatic logic signed [71:0] ext72(input logic signed [31:0] a);
        return $signed({{40{a[31]}}, a});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        if (v > SAT_HI) return Q_MAX;
        if (v < SAT_LO) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [71:0] w;
        p = a * b;
        w = ($signed({{8{p[63]}}, p}) + HALF_Q) >>> FRAC;
        return sat32(w);
    endfunction

    function automatic logic signed [31:0] normalize(input logic [15:0] pix,
                                                     input logic [15:0] ctr,
                                                     input logic [31:0] inv);
        logic signed [16:0] d;
        logic signed [49:0] p;
        logic signed [71:0] w;
        d = $signed({1'b0, pix}) - $signed({1'b0, ctr});
        p = d * $signed({1'b0, inv});
        w = ($signed({{22{p[49]}}, p}) + 72'sd128) >>> 8;
        return sat32(w);
    endfunction

    function automatic logic signed [31:0] scale_depth(input logic signed [31:0] c,
                                                       input logic [31:0] depth);
        logic signed [64:0] p;
        logic signed [71:0] w;
        p = c * $signed({1'b0, depth});
        w = ($signed({{7{p[64]}}, p}) + HALF_Q) >>> FRAC;
        return sat32(w);
    endfunction

endpackage
`default_nettype wire

[design/pdu_div.sv]
`default_nettype none
// Pipelined signed Q4.28 divider: (num << 28) / den, truncated, saturated.
// One quotient bit per stage; all lanes share the divisor.
module pdu_div #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            en,
    input  wire                            in_valid,
    input  wire logic signed [LANES-1:0][31:0] num,
    input  wire logic signed [31:0]        den,
    input  wire logic [SIDE_W-1:0]         side_in,
    output logic                           out_valid,
    output logic signed [LANES-1:0][31:0]  quo,
    output logic [SIDE_W-1:0]              side_out
);
    import pdu_pkg::*;

    logic [LANES-1:0][31:0] rem_reg [0:DIV_STEPS];
    logic [LANES-1:0][31:0] q_reg   [0:DIV_STEPS];
    logic [LANES-1:0][3:0]  lo_reg  [0:DIV_STEPS];
    dflag_t [LANES-1:0]     fl_reg  [0:DIV_STEPS];
    logic [31:0]            dv_reg  [0:DIV_STEPS];
    logic                   dz_reg  [0:DIV_STEPS];
    logic [SIDE_W-1:0]      sd_reg  [0:DIV_STEPS];
    logic [DIV_STEPS:0]     vld_reg;
    logic                   out_valid_reg;
    logic signed [LANES-1:0][31:0] quo_reg;
    logic [SIDE_W-1:0]      side_out_reg;

    logic [LANES-1:0][31:0] absa;
    dflag_t [LANES-1:0]     fl_next;
    logic [31:0]            absd;

    function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                             input logic [31:0] d);
        logic [32:0] t;
        logic [32:0] s;
        t = {r, b};
        s = t - {1'b0, d};
        if (t >= {1'b0, d}) return {1'b1, s[31:0]};
        return {1'b0, t[31:0]};
    endfunction

    function automatic logic signed [31:0] finish(input logic [31:0] q, input dflag_t f,
                                                  input logic dz);
        if (dz) begin
            if (f.apos) return Q_MAX;
            if (f.aneg) return Q_MIN;
            return 32'sd0;
        end
        if (f.ovf) return f.neg ? Q_MIN : Q_MAX;
        if (f.neg) begin
            if (q > 32'h8000_0000) return Q_MIN;
            return $signed(~q + 32'd1);
        end
        if (q[31]) return Q_MAX;
        return $signed(q);
    endfunction

    always_comb begin
        absd = den[31] ? (~den + 32'd1) : den;
        for (int l = 0; l < LANES; l++) begin
            absa[l] = num[l][31] ? (~num[l] + 32'd1) : num[l];
            fl_next[l].aneg = num[l][31];
            fl_next[l].apos = !num[l][31] && (num[l] != 32'sd0);
            fl_next[l].neg  = num[l][31] ^ den[31];
            fl_next[l].ovf  = {4'b0, absa[l]} >= {absd, 4'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-1:0], in_valid};
            out_valid_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= {4'b0, absa[l][31:4]};
                q_reg[0][l]   <= '0;
                lo_reg[0][l]  <= absa[l][3:0];
            end
            fl_reg[0] <= fl_next;
            dv_reg[0] <= absd;
            dz_reg[0] <= (den == 32'sd0);
            sd_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [LANES-1:0][32:0] st;
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                st[l] = div_step(rem_reg[k-1][l], lo_reg[k-1][l][3], dv_reg[k-1]);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k][l] <= st[l][31:0];
                    q_reg[k][l]   <= {q_reg[k-1][l][30:0], st[l][32]};
                    lo_reg[k][l]  <= {lo_reg[k-1][l][2:0], 1'b0};
                end
                fl_reg[k] <= fl_reg[k-1];
                dv_reg[k] <= dv_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                quo_reg[l] <= finish(q_reg[DIV_STEPS][l], fl_reg[DIV_STEPS][l],
                                     dz_reg[DIV_STEPS]);
            end
            side_out_reg <= sd_reg[DIV_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;
    assign side_out  = side_out_reg;

endmodule
`default_nettype wire

[design/pdu_iter_cell.sv]
`default_nettype none
// One undistortion iteration: xu' = (xd - dx) / kr, yu' = (yd - dy) / kr.
module pdu_iter_cell (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      en,
    input  wire pdu_pkg::coef_t      coef,
    input  wire                      in_valid,
    input  wire pdu_pkg::item_t      in_item,
    input  wire logic signed [31:0]  in_xu,
    input  wire logic signed [31:0]  in_yu,
    output logic                     out_valid,
    output pdu_pkg::item_t           out_item,
    output logic signed [31:0]       out_yu,
    output logic signed [31:0]       out_xu
);
    import pdu_pkg::*;

    logic [5:0] vld_reg;
    item_t it_reg [1:6];

    logic signed [31:0] s1_xx_reg, s1_yy_reg, s1_xy_reg;
    logic signed [31:0] s2_r2_reg, s2_tx_reg, s2_ty_reg, s2_xy_reg;
    logic signed [31:0] s3_r4_reg, s3_r2_reg, s3_t1_reg, s3_pxy_reg;
    logic signed [31:0] s3_p2tx_reg, s3_p1ty_reg, s3_p2xy_reg;
    logic signed [31:0] s4_r6_reg, s4_k2r4_reg, s4_t1_reg, s4_nx_reg, s4_ny_reg;
    logic signed [31:0] s5_k3r6_reg, s5_nx_reg, s5_ny_reg;
    logic signed [32:0] s5_sum_reg;
    logic signed [31:0] s6_kr_reg, s6_nx_reg, s6_ny_reg;

    logic signed [31:0] r2_next, dx_next, dy_next;

    always_comb begin
        r2_next = sat32(ext72(s1_xx_reg) + ext72(s1_yy_reg));
        dx_next = sat32((ext72(s3_pxy_reg) <<< 1) + ext72(s3_p2tx_reg));
        dy_next = sat32(ext72(s3_p1ty_reg) + (ext72(s3_p2xy_reg) <<< 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it_reg[1] <= in_item;
            for (int i = 2; i <= 6; i++) it_reg[i] <= it_reg[i-1];

            s1_xx_reg <= qmul(in_xu, in_xu);
            s1_yy_reg <= qmul(in_yu, in_yu);
            s1_xy_reg <= qmul(in_xu, in_yu);

            s2_r2_reg <= r2_next;
            s2_tx_reg <= sat32(ext72(r2_next) + (ext72(s1_xx_reg) <<< 1));
            s2_ty_reg <= sat32(ext72(r2_next) + (ext72(s1_yy_reg) <<< 1));
            s2_xy_reg <= s1_xy_reg;

            s3_r4_reg   <= qmul(s2_r2_reg, s2_r2_reg);
            s3_r2_reg   <= s2_r2_reg;
            s3_t1_reg   <= qmul(coef.k1, s2_r2_reg);
            s3_pxy_reg  <= qmul(coef.p1, s2_xy_reg);
            s3_p2tx_reg <= qmul(coef.p2, s2_tx_reg);
            s3_p1ty_reg <= qmul(coef.p1, s2_ty_reg);
            s3_p2xy_reg <= qmul(coef.p2, s2_xy_reg);

            s4_r6_reg   <= qmul(s3_r4_reg, s3_r2_reg);
            s4_k2r4_reg <= qmul(coef.k2, s3_r4_reg);
            s4_t1_reg   <= s3_t1_reg;
            s4_nx_reg   <= sat32(ext72(it_reg[3].xd) - ext72(dx_next));
            s4_ny_reg   <= sat32(ext72(it_reg[3].yd) - ext72(dy_next));

            s5_k3r6_reg <= qmul(coef.k3, s4_r6_reg);
            s5_sum_reg  <= 33'(ext72(s4_t1_reg) + ext72(s4_k2r4_reg));
            s5_nx_reg   <= s4_nx_reg;
            s5_ny_reg   <= s4_ny_reg;

            s6_kr_reg <= sat32(ext72(ONE_Q) + $signed({{39{s5_sum_reg[32]}}, s5_sum_reg})
                               + ext72(s5_k3r6_reg));
            s6_nx_reg <= s5_nx_reg;
            s6_ny_reg <= s5_ny_reg;
        end
    end

    logic signed [1:0][31:0] quo;

    pdu_div #(
        .LANES  (2),
        .SIDE_W ($bits(item_t))
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_reg[5]),
        .num      ({s6_ny_reg, s6_nx_reg}),
        .den      (s6_kr_reg),
        .side_in  (it_reg[6]),
        .out_valid(out_valid),
        .quo      (quo),
        .side_out (out_item)
    );

    assign out_xu = quo[0];
    assign out_yu = quo[1];

endmodule
`default_nettype wire

[design/pdu_k1_path.sv]
`default_nettype none
// k1-only two-step correction; the iteration result rides along as sideband.
module pdu_k1_path (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      en,
    input  wire logic signed [31:0]  k1,
    input  wire                      in_valid,
    input  wire pdu_pkg::item_t      in_item,
    input  wire logic signed [31:0]  in_xi,
    input  wire logic signed [31:0]  in_yi,
    output logic                     out_valid,
    output pdu_pkg::item_t           out_item,
    output logic signed [31:0]       out_xi,
    output logic signed [31:0]       out_yi,
    output logic signed [31:0]       out_xk,
    output logic signed [31:0]       out_yk
);
    import pdu_pkg::*;

    localparam int SW = $bits(item_t) + 64;

    logic [SW-1:0] sd_reg [1:4];
    logic [3:0]    vld_a_reg;
    logic signed [31:0] a1_xx_reg, a1_yy_reg, a2_rd2_reg, a3_rd2_reg, a3_m_reg;
    logic signed [31:0] a4_rd2_reg, a4_rdist_reg;

    logic [SW-1:0] sd_b [0:2];
    logic [1:0]    vld_b_reg;
    logic          vld_b0;
    logic signed [0:0][31:0] ru2;
    logic signed [31:0] b1_m_reg, b2_rdist_reg;
    item_t b2_item;

    assign b2_item = item_t'(sd_b[2][$bits(item_t)-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= '0;
            vld_b_reg <= '0;
        end else if (en) begin
            vld_a_reg <= {vld_a_reg[2:0], in_valid};
            vld_b_reg <= {vld_b_reg[0], vld_b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[1] <= {in_yi, in_xi, in_item};
            for (int i = 2; i <= 4; i++) sd_reg[i] <= sd_reg[i-1];
            a1_xx_reg    <= qmul(in_item.xd, in_item.xd);
            a1_yy_reg    <= qmul(in_item.yd, in_item.yd);
            a2_rd2_reg   <= sat32(ext72(a1_xx_reg) + ext72(a1_yy_reg));
            a3_rd2_reg   <= a2_rd2_reg;
            a3_m_reg     <= qmul(k1, a2_rd2_reg);
            a4_rd2_reg   <= a3_rd2_reg;
            a4_rdist_reg <= sat32(ext72(ONE_Q) + ext72(a3_m_reg));

            sd_b[1]      <= sd_b[0];
            sd_b[2]      <= sd_b[1];
            b1_m_reg     <= qmul(k1, ru2[0]);
            b2_rdist_reg <= sat32(ext72(ONE_Q) + ext72(b1_m_reg));
        end
    end

    pdu_div #(
        .LANES  (1),
        .SIDE_W (SW)
    ) u_div_r (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_a_reg[3]),
        .num      (a4_rd2_reg),
        .den      (a4_rdist_reg),
        .side_in  (sd_reg[4]),
        .out_valid(vld_b0),
        .quo      (ru2),
        .side_out (sd_b[0])
    );

    logic signed [1:0][31:0] quo;
    logic [SW-1:0] sd_out;

    pdu_div #(
        .LANES  (2),
        .SIDE_W (SW)
    ) u_div_xy (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_b_reg[1]),
        .num      ({b2_item.yd, b2_item.xd}),
        .den      (b2_rdist_reg),
        .side_in  (sd_b[2]),
        .out_valid(out_valid),
        .quo      (quo),
        .side_out (sd_out)
    );

    assign out_item = item_t'(sd_out[$bits(item_t)-1:0]);
    assign out_xi   = $signed(sd_out[$bits(item_t)+31:$bits(item_t)]);
    assign out_yi   = $signed(sd_out[SW-1:$bits(item_t)+32]);
    assign out_xk   = quo[0];
    assign out_yk   = quo[1];

endmodule
`default_nettype wire

[design/pixel_depth_undistort_backproject_unit.sv]
`default_nettype none
// channel  | dir | tdata fields (low bit up)              | tuser / tlast
// s_       | in  | pixel_u[15:0] pixel_v[31:16] depth[63:32] | none
// m_       | out | out_x[31:0] out_y[63:32] out_z[95:64]     | none
// cfg      | in  | write enable, 3-bit register index, 32-bit data
//
// One word per cycle in and out unless the output buffer is full and m_tready
// low. Stages: one normalize, 40 per iteration cell (6 arithmetic stages and a
// 34-stage bit-per-stage divider), 74 in the k1-only path, one depth-scale stage.
// Reset (synchronous, aresetn low) clears valids, buffer count and cfg registers.
// The whole pipeline advances together; a two-word output buffer keeps s_tready
// high while one result waits and drops it only when both entries are held.
module pixel_depth_undistort_backproject_unit #(
    parameter int ITERATIONS = 20
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // pixel_u, pixel_v, depth
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata,   // out_x, out_y, out_z
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_addr,
    input  wire  [31:0] cfg_wdata
);
    import pdu_pkg::*;

    logic [31:0] inv_fx_reg, inv_fy_reg, pp_reg;
    coef_t coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_fx_reg <= '0;
            inv_fy_reg <= '0;
            pp_reg     <= '0;
            coef_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_INV_FX: inv_fx_reg  <= cfg_wdata;
                REG_INV_FY: inv_fy_reg  <= cfg_wdata;
                REG_PP:     pp_reg      <= cfg_wdata;
                REG_K1:     coef_reg.k1 <= $signed(cfg_wdata);
                REG_K2:     coef_reg.k2 <= $signed(cfg_wdata);
                REG_K3:     coef_reg.k3 <= $signed(cfg_wdata);
                REG_P1:     coef_reg.p1 <= $signed(cfg_wdata);
                REG_P2:     coef_reg.p2 <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    logic       en;
    logic [1:0] cnt_reg;

    assign en       = (cnt_reg != 2'd2) || m_tready;
    assign s_tready = en;

    // normalize stage
    logic  n_valid_reg;
    item_t n_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (en) begin
            n_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_item_reg.xd    <= normalize(s_tdata[15:0], pp_reg[15:0], inv_fx_reg);
            n_item_reg.yd    <= normalize(s_tdata[31:16], pp_reg[31:16], inv_fy_reg);
            n_item_reg.depth <= s_tdata[63:32];
        end
    end

    logic               c_valid [0:ITERATIONS];
    item_t              c_item  [0:ITERATIONS];
    logic signed [31:0] c_xu    [0:ITERATIONS];
    logic signed [31:0] c_yu    [0:ITERATIONS];

    assign c_valid[0] = n_valid_reg;
    assign c_item[0]  = n_item_reg;
    assign c_xu[0]    = n_item_reg.xd;
    assign c_yu[0]    = n_item_reg.yd;

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
        pdu_iter_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .coef     (coef_reg),
            .in_valid (c_valid[i]),
            .in_item  (c_item[i]),
            .in_xu    (c_xu[i]),
            .in_yu    (c_yu[i]),
            .out_valid(c_valid[i+1]),
            .out_item (c_item[i+1]),
            .out_yu   (c_yu[i+1]),
            .out_xu   (c_xu[i+1])
        );
    end

    logic               k_valid;
    item_t              k_item;
    logic signed [31:0] k_xi, k_yi, k_xk, k_yk;

    pdu_k1_path u_k1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .k1       (coef_reg.k1),
        .in_valid (c_valid[ITERATIONS]),
        .in_item  (c_item[ITERATIONS]),
        .in_xi    (c_xu[ITERATIONS]),
        .in_yi    (c_yu[ITERATIONS]),
        .out_valid(k_valid),
        .out_item (k_item),
        .out_xi   (k_xi),
        .out_yi   (k_yi),
        .out_xk   (k_xk),
        .out_yk   (k_yk)
    );

    // mode select: no correction, k1-only, or iterated
    logic signed [31:0] sel_x, sel_y;

    always_comb begin
        if (coef_reg.k1 == 32'sd0) begin
            sel_x = k_item.xd;
            sel_y = k_item.yd;
        end else if (coef_reg.k2 == 32'sd0) begin
            sel_x = k_xk;
            sel_y = k_yk;
        end else begin
            sel_x = k_xi;
            sel_y = k_yi;
        end
    end

    logic        f_valid_reg;
    logic [95:0] f_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= k_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_data_reg <= {k_item.depth, scale_depth(sel_y, k_item.depth),
                           scale_depth(sel_x, k_item.depth)};
        end
    end

    // two-word output buffer, e0 is the head
    logic        push, pop;
    logic [95:0] e0_reg, e1_reg;

    assign push = en && f_valid_reg;
    assign pop  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !pop) begin
            if (cnt_reg == 2'd0) e0_reg <= f_data_reg;
            else e1_reg <= f_data_reg;
        end else if (pop && !push) begin
            e0_reg <= e1_reg;
        end else if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                e0_reg <= f_data_reg;
            end else begin
                e0_reg <= e1_reg;
                e1_reg <= f_data_reg;
            end
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = e0_reg;

endmodule
`default_nettype wire

[design/pdu_checker.sv]
`default_nettype none
module pdu_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [95:0] m_tdata
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output buffer");

    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind pixel_depth_undistort_backproject_unit pdu_checker u_pdu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire

[tb/pixel_depth_undistort_backproject_unit_tb.sv]
`timescale 1ns / 1ps
module pixel_depth_undistort_backproject_unit_tb;
    import pdu_pkg::*;

    localparam int ITER = 20;
    localparam int LATENCY = 40 * ITER + 80;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
        logic [31:0] depth;
    } pixel_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        z;
    } point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    pixel_t pending_px[$];
    point_t expected_pts[$];
    int     errors = 0;
    int     cycles = 0;
    int     idle_mode = 0;

    // mirror of the register file
    logic [31:0] m_ifx, m_ify, m_pp;
    int          m_k1, m_k2, m_k3, m_p1, m_p2;

    pixel_depth_undistort_backproject_unit #(.ITERATIONS(ITER)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int sat_q(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int mul_q(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat_q((p + (64'sd1 <<< 27)) >>> 28);
    endfunction

    function automatic int div_q(int a, int d);
        if (d == 0) begin
            if (a > 0) return 32'sh7fffffff;
            if (a < 0) return 32'sh80000000;
            return 0;
        end
        return sat_q((longint'(a) <<< 28) / longint'(d));
    endfunction

    function automatic int norm_q(logic [15:0] pix, logic [15:0] ctr, logic [31:0] inv);
        longint d;
        d = longint'(pix) - longint'(ctr);
        return sat_q((d * longint'(inv) + 128) >>> 8);
    endfunction

    function automatic int depth_scale(int c, logic [31:0] depth);
        return sat_q((longint'(c) * longint'(depth) + (64'sd1 <<< 27)) >>> 28);
    endfunction

    function automatic point_t backproject(pixel_t px);
        point_t r;
        int xd, yd, xu, yu, rd2, rdist, ru2;
        int xx, yy, xy, r2, r4, r6, kr, tx, ty, dx, dy;
        longint one;
        one = 64'sd1 <<< 28;
        xd = norm_q(px.u, m_pp[15:0], m_ifx);
        yd = norm_q(px.v, m_pp[31:16], m_ify);
        xu = xd;
        yu = yd;
        if (m_k1 == 0) begin
            // no correction
        end else if (m_k2 == 0) begin
            rd2 = sat_q(longint'(mul_q(xd, xd)) + mul_q(yd, yd));
            rdist = sat_q(one + mul_q(m_k1, rd2));
            ru2 = div_q(rd2, rdist);
            rdist = sat_q(one + mul_q(m_k1, ru2));
            xu = div_q(xd, rdist);
            yu = div_q(yd, rdist);
        end else begin
            for (int i = 0; i < ITER; i++) begin
                xx = mul_q(xu, xu);
                yy = mul_q(yu, yu);
                xy = mul_q(xu, yu);
                r2 = sat_q(longint'(xx) + yy);
                r4 = mul_q(r2, r2);
                r6 = mul_q(r4, r2);
                kr = sat_q(one + longint'(mul_q(m_k1, r2)) + mul_q(m_k2, r4)
                           + mul_q(m_k3, r6));
                tx = sat_q(longint'(r2) + 2 * longint'(xx));
                ty = sat_q(longint'(r2) + 2 * longint'(yy));
                dx = sat_q(2 * longint'(mul_q(m_p1, xy)) + mul_q(m_p2, tx));
                dy = sat_q(longint'(mul_q(m_p1, ty)) + 2 * longint'(mul_q(m_p2, xy)));
                xu = div_q(sat_q(longint'(xd) - dx), kr);
                yu = div_q(sat_q(longint'(yd) - dy), kr);
            end
        end
        r.x = depth_scale(xu, px.depth);
        r.y = depth_scale(yu, px.depth);
        r.z = px.depth;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_pts.push_back(backproject('{s_tdata[15:0], s_tdata[31:16],
                                                     s_tdata[63:32]}));
            if (!s_tvalid || s_tready) begin
                if (pending_px.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(99) < 70) ||
                      (idle_mode == 3 && $urandom_range(99) < 37))) begin
                    pixel_t p;
                    p = pending_px.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {p.depth, p.v, p.u};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !((idle_mode == 2 && $urandom_range(99) < 70) ||
                          (idle_mode == 3 && $urandom_range(99) < 37));
            if (m_tvalid && m_tready) begin
                if (expected_pts.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
                end else begin
                    point_t e;
                    e = expected_pts.pop_front();
                    if (m_tdata[31:0] !== e.x) report_mismatch("out_x", m_tdata[31:0], e.x);
                    if (m_tdata[63:32] !== e.y) report_mismatch("out_y", m_tdata[63:32], e.y);
                    if (m_tdata[95:64] !== e.z) report_mismatch("out_z", m_tdata[95:64], e.z);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_INV_FX: m_ifx = val;
            REG_INV_FY: m_ify = val;
            REG_PP:     m_pp = val;
            REG_K1:     m_k1 = val;
            REG_K2:     m_k2 = val;
            REG_K3:     m_k3 = val;
            REG_P1:     m_p1 = val;
            default:    m_p2 = val;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] fx, logic [31:0] fy, logic [31:0] pp,
                           logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                           logic [31:0] p1, logic [31:0] p2);
        write_reg(REG_INV_FX, fx);
        write_reg(REG_INV_FY, fy);
        write_reg(REG_PP, pp);
        write_reg(REG_K1, k1);
        write_reg(REG_K2, k2);
        write_reg(REG_K3, k3);
        write_reg(REG_P1, p1);
        write_reg(REG_P2, p2);
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_px.size() != 0 || s_tvalid || expected_pts.size() != 0);
        repeat (5) @(posedge aclk);
    endtask

    task automatic add_px(logic [15:0] u, logic [15:0] v, logic [31:0] d);
        pending_px.push_back('{u, v, d});
    endtask

    // mostly modest coefficients, sometimes the full range
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_inv();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return $urandom;
            default: return $urandom_range(32'h0200_0000, 32'h0040_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] k1, k2;
        m_ifx = 0; m_ify = 0; m_pp = 0;
        m_k1 = 0; m_k2 = 0; m_k3 = 0; m_p1 = 0; m_p2 = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // k1-only with k1 = -1 and radius 1: radial divisor hits zero
        set_all(32'h1000_0000, 32'h1000_0000, 32'h0, 32'hf000_0000, 0, 0, 0, 0);
        add_px(16'd256, 16'd0, 32'h0001_0000);
        add_px(16'd0, 16'd256, 32'h0001_0000);
        add_px(16'd0, 16'd0, 32'h0);
        add_px(16'hffff, 16'hffff, 32'hffff_ffff);
        add_px(16'd0, 16'd0, 32'hffff_ffff);
        drain();
        // iterative, extreme coefficients and geometry: saturation everywhere
        set_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        add_px(16'd0, 16'd0, 32'hffff_ffff);
        add_px(16'hffff, 16'hffff, 32'hffff_ffff);
        add_px(16'hffff, 16'd0, 32'h0001_0000);
        add_px(16'd0, 16'hffff, 32'h0);
        add_px(16'hffff, 16'hffff, 32'h0);
        drain();
        // iterative, kr driven to one LSB at radius 1, and a pixel at the origin
        set_all(32'h1000_0000, 32'h1000_0000, 32'h0000_0000, 32'hf000_0000,
                32'h0000_0001, 32'h0, 32'h0, 32'h0);
        add_px(16'd256, 16'd0, 32'h0001_0000);
        add_px(16'd0, 16'd0, 32'h0001_0000);
        drain();
        // no correction
        set_all(32'hffff_ffff, 32'h0, 32'h8000_8000, 0, 32'h8000_0000, 0, 0, 0);
        add_px(16'd0, 16'd0, 32'hffff_ffff);
        add_px(16'hffff, 16'hffff, 32'hffff_ffff);
        add_px(16'h8000, 16'h8000, 32'h1234_5678);
        drain();

        for (int ph = 0; ph < 26; ph++) begin
            idle_mode = ph % 4;
            k1 = (ph % 3 == 0) ? 32'h0 : rand_coef();
            if (k1 == 0 && ph % 3 != 0) k1 = 32'h0100_0000;
            k2 = (ph % 3 == 1) ? 32'h0 : rand_coef();
            set_all(rand_inv(), rand_inv(), $urandom, k1, k2,
                    rand_coef(), rand_coef(), rand_coef());
            for (int i = 0; i < 75; i++) begin
                if ($urandom_range(3) == 0)
                    add_px(16'($urandom), 16'($urandom), $urandom);
                else
                    add_px(16'(m_pp[15:0] + $urandom_range(16'h1000) - 16'h0800),
                           16'(m_pp[31:16] + $urandom_range(16'h1000) - 16'h0800),
                           $urandom_range(32'h0100_0000));
            end
            drain();
        end

        repeat (LATENCY) @(posedge aclk);
        if (errors == 0 && expected_pts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[pixel_depth_undistort_backproject_unit.f]
design/pdu_pkg.sv
design/pdu_div.sv
design/pdu_iter_cell.sv
design/pdu_k1_path.sv
design/pixel_depth_undistort_backproject_unit.sv
design/pdu_checker.sv
tb/pixel_depth_undistort_backproject_unit_tb.sv
